// File: src/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg: shared types and constants of the motor feedback decoder
// Field widths, register addresses and the sequencer state type.
// ----------------------------------------------------------------------------
package mfd_pkg;

	localparam int unsigned ENC_WRAP     = 8191;
	localparam int unsigned HALF_TURN    = 4096;
	localparam int unsigned STALL_FRAMES = 10;
	localparam int unsigned MUL_STEPS    = 32;   // bits of a serial multiplier operand

	localparam logic [2:0] REG_OFFSET   = 3'd0;
	localparam logic [2:0] REG_SPD_W    = 3'd1;
	localparam logic [2:0] REG_CUR_W    = 3'd2;
	localparam logic [2:0] REG_ENABLES  = 3'd3;
	localparam logic [2:0] REG_STALL_SP = 3'd4;
	localparam logic [2:0] REG_STALL_CU = 3'd5;
	localparam logic [2:0] REG_CRASH_S  = 3'd6;
	localparam logic [2:0] REG_MOTOR_EN = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;      // signed multiplicand
		logic [31:0] b;      // unsigned multiplier
	} mul_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic [12:0] position_offset;
		logic [15:0] speed_smoothing;
		logic [15:0] current_smoothing;
		logic [1:0]  detection_enables;
		logic [25:0] stall_speed;
		logic [14:0] stall_current;
		logic [7:0]  crash_sensitivity;
		logic        motor_on;
	} cfg_t;

endpackage

// File: src/mfd_if.sv
// ----------------------------------------------------------------------------
// mfd_in_if / mfd_out_if: valid/ready channels of the decoder
// One beat carries one feedback frame or one decoded result.
// ----------------------------------------------------------------------------
interface mfd_in_if;
	logic               valid;
	logic               ready;
	logic        [12:0] position_raw;
	logic signed [15:0] speed_rpm;
	logic signed [15:0] current_raw;
	logic        [7:0]  temperature;
	logic signed [15:0] drive_current;
	modport source (output valid, position_raw, speed_rpm, current_raw, temperature,
		drive_current, input ready);
	modport sink (input valid, position_raw, speed_rpm, current_raw, temperature,
		drive_current, output ready);
endinterface

interface mfd_out_if;
	logic               valid;
	logic               ready;
	logic        [12:0] corrected_position;
	logic        [24:0] single_turn_angle;
	logic signed [31:0] turn_count;
	logic signed [47:0] multiturn_angle;
	logic signed [26:0] filtered_speed;
	logic signed [23:0] filtered_current;
	logic        [7:0]  temperature_out;
	logic               crash_flag;
	logic               stall_flag;
	modport source (output valid, corrected_position, single_turn_angle, turn_count,
		multiturn_angle, filtered_speed, filtered_current, temperature_out, crash_flag,
		stall_flag, input ready);
	modport sink (input valid, corrected_position, single_turn_angle, turn_count,
		multiturn_angle, filtered_speed, filtered_current, temperature_out, crash_flag,
		stall_flag, output ready);
endinterface

// File: src/motor_feedback_decoder.sv
// ----------------------------------------------------------------------------
// motor_feedback_decoder: multiturn encoder tracking with stall detect
// Decodes one feedback frame per beat into angle, turns, filtered values
// and sticky crash/stall flags.
// ----------------------------------------------------------------------------
// Usage:
//  - in: one feedback frame per beat (valid/ready). out: one result per frame.
//  - APB port sets the eight configuration registers; the user must do
//    so only while the block is idle, which the block does not enforce.
//  - Each frame runs through a sequencer that drives one bit-serial
//    multiplier (one multiplier bit a cycle). Six products are needed:
//    two per filter, one for the crash threshold and one for turns*360
//    deg. Each product goes through start, one step per multiplier bit
//    and done. Frames are handled one at a time, and a new frame is
//    taken only after the previous result has left on out.ready.
//  - in.ready is high only in idle; a result waits in the output register
//    until out.ready, and no new frame is taken meanwhile.
//  - Reset clears turn count, filters, stall counter and flags, and restores
//    register defaults.
// ----------------------------------------------------------------------------
module motor_feedback_decoder (
	input  logic        clk,
	input  logic        arst_n,
	mfd_in_if.sink      in,
	mfd_out_if.source   out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	mfd_pkg::cfg_t     cfg;
	mfd_pkg::mul_req_t mreq;
	mfd_pkg::mul_rsp_t mrsp;
	mfd_pkg::state_t   state_q, state_d;

	mfd_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);
	mfd_serial_mul u_mul (.clk, .arst_n, .req(mreq), .rsp(mrsp));

	// frame capture
	logic signed [15:0] rpm_q, cur_q;
	logic [15:0]        drive_mag_q;
	logic [7:0]         temp_q;
	logic [12:0]        pos_q;

	// tracked state
	logic [12:0]        prev_pos_q;
	logic signed [31:0] turns_q;
	logic signed [26:0] spd_f_q;
	logic signed [23:0] cur_f_q;
	logic [7:0]         stall_cnt_q;
	logic               crash_q, stall_q;

	logic [2:0]         op_q;      // which product is in flight
	logic signed [63:0] acc_q;     // filter accumulator
	logic signed [26:0] last_spd_q;
	logic signed [63:0] prod_q;    // crash product

	// result register
	logic               ovalid_q;
	logic signed [47:0] total_q;

	// position correction and turn step from raw input
	logic [12:0] pos_new;
	logic signed [14:0] diff;
	always_comb begin
		if (in.position_raw >= cfg.position_offset)
			pos_new = in.position_raw - cfg.position_offset;
		else
			pos_new = 13'(14'(in.position_raw) + 14'(mfd_pkg::ENC_WRAP)
				- 14'(cfg.position_offset));
		diff = $signed({2'b0, pos_new}) - $signed({2'b0, prev_pos_q});
	end

	logic accept;
	assign accept   = in.valid && in.ready;
	assign in.ready = (state_q == mfd_pkg::ST_IDLE);

	// operand of each product
	always_comb begin
		mreq.a = '0;
		mreq.b = '0;
		case (op_q)
			3'd0: begin mreq.a = 64'(spd_f_q);
				mreq.b = 32'(17'h10000 - 17'(cfg.speed_smoothing)); end
			3'd1: begin mreq.a = 64'(rpm_q) * 64'sd1536;
				mreq.b = 32'(cfg.speed_smoothing); end
			3'd2: begin mreq.a = 64'(cur_f_q);
				mreq.b = 32'(17'h10000 - 17'(cfg.current_smoothing)); end
			3'd3: begin mreq.a = {{40{cur_q[15]}}, cur_q, 8'd0};
				mreq.b = 32'(cfg.current_smoothing); end
			3'd4: begin mreq.a = (last_spd_q < 0 ? -64'(last_spd_q) : 64'(last_spd_q))
				- (spd_f_q < 0 ? -64'(spd_f_q) : 64'(spd_f_q));
				mreq.b = 32'(cfg.crash_sensitivity); end
			3'd5: begin mreq.a = 64'(turns_q); mreq.b = 32'd23592960; end
			default: ;
		endcase
	end
	assign mreq.start = (state_q == mfd_pkg::ST_MUL) && !mrsp.busy && !mrsp.done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mfd_pkg::ST_IDLE: if (accept) state_d = mfd_pkg::ST_MUL;
			mfd_pkg::ST_MUL:  if (mrsp.done && op_q == 3'd5) state_d = mfd_pkg::ST_FIN;
			mfd_pkg::ST_FIN:  state_d = mfd_pkg::ST_OUT;
			mfd_pkg::ST_OUT:  if (out.ready) state_d = mfd_pkg::ST_IDLE;
			default:          state_d = mfd_pkg::ST_IDLE;
		endcase
	end

	// filter rounding and clamping helpers
	logic signed [63:0] rnd;
	logic signed [47:0] flt;
	assign rnd = acc_q + mrsp.p + 64'sd32768;
	assign flt = 48'(rnd >>> 16);

	logic signed [63:0] la, na, tot;
	assign la  = last_spd_q < 0 ? -64'(last_spd_q) : 64'(last_spd_q);
	assign na  = spd_f_q < 0 ? -64'(spd_f_q) : 64'(spd_f_q);
	assign tot = mrsp.p + 64'(out.single_turn_angle);

	logic high_drive;
	assign high_drive = {1'b0, drive_mag_q} > {2'b0, cfg.stall_current};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mfd_pkg::ST_IDLE;
			op_q        <= '0;
			prev_pos_q  <= '0;
			turns_q     <= '0;
			spd_f_q     <= '0;
			cur_f_q     <= '0;
			stall_cnt_q <= '0;
			crash_q     <= 1'b0;
			stall_q     <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q       <= '0;
				prev_pos_q <= pos_new;
				if (diff > 15'sd4096)       turns_q <= turns_q - 32'sd1;
				else if (diff < -15'sd4096) turns_q <= turns_q + 32'sd1;
			end
			if (state_q == mfd_pkg::ST_MUL && mrsp.done) begin
				op_q <= op_q + 3'd1;
				case (op_q)
					3'd1: spd_f_q <= flt > 48'sd50331647 ? 27'sd50331647 :
						flt < -48'sd50331648 ? -27'sd50331648 : 27'(flt);
					3'd3: cur_f_q <= flt > 48'sd8388607 ? 24'sd8388607 :
						flt < -48'sd8388608 ? -24'sd8388608 : 24'(flt);
					default: ;
				endcase
			end
			if (state_q == mfd_pkg::ST_FIN) begin
				if (cfg.detection_enables[0] && !crash_q && cfg.motor_on && high_drive
					&& prod_q > la && la > 64'(cfg.stall_speed))
					crash_q <= 1'b1;
				if (cfg.detection_enables[1]) begin
					if (!stall_q && cfg.motor_on && high_drive
						&& na < 64'(cfg.stall_speed)) begin
						if (stall_cnt_q != 8'd255) stall_cnt_q <= stall_cnt_q + 8'd1;
						if (stall_cnt_q + 9'd1 > 9'(mfd_pkg::STALL_FRAMES)
							&& stall_cnt_q != 8'd255 || stall_cnt_q > 8'(mfd_pkg::STALL_FRAMES))
							stall_q <= 1'b1;
					end else
						stall_cnt_q <= '0;
				end
				ovalid_q <= 1'b1;
			end
			if (ovalid_q && out.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rpm_q       <= in.speed_rpm;
			cur_q       <= in.current_raw;
			temp_q      <= in.temperature;
			drive_mag_q <= in.drive_current[15] ? 16'(-in.drive_current) : in.drive_current;
			pos_q       <= pos_new;
			last_spd_q  <= spd_f_q;
		end
		if (state_q == mfd_pkg::ST_MUL && mrsp.done) begin
			case (op_q)
				3'd0, 3'd2: acc_q <= mrsp.p;
				3'd4:       prod_q <= mrsp.p;
				3'd5: total_q <= tot > 64'sh7FFFFFFFFFFF ? 48'sh7FFFFFFFFFFF :
					tot < -64'sh800000000000 ? 48'sh800000000000 : 48'(tot);
				default: ;
			endcase
		end
	end

	assign out.valid              = ovalid_q;
	assign out.corrected_position = pos_q;
	assign out.single_turn_angle  = 25'(pos_q) * 25'd2880;
	assign out.turn_count         = turns_q;
	assign out.multiturn_angle    = total_q;
	assign out.filtered_speed     = spd_f_q;
	assign out.filtered_current   = cur_f_q;
	assign out.temperature_out    = temp_q;
	assign out.crash_flag         = crash_q;
	assign out.stall_flag         = stall_q;
endmodule

// File: src/mfd_serial_mul.sv
// ----------------------------------------------------------------------------
// mfd_serial_mul: bit-serial shift-and-add multiplier
// Signed 64-bit multiplicand times unsigned 32-bit multiplier, one bit a cycle.
// ----------------------------------------------------------------------------
module mfd_serial_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mfd_pkg::mul_req_t req,
	output mfd_pkg::mul_rsp_t rsp
);
	logic [63:0] a_q;
	logic [31:0] b_q;
	logic [63:0] acc_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(mfd_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: operand a shifts left, b shifts right
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= {a_q[62:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.p    = acc_q;
endmodule

// File: src/mfd_regs.sv
// ----------------------------------------------------------------------------
// mfd_regs: APB register file
// Eight configuration registers at byte address 4*i, readable.
// ----------------------------------------------------------------------------
module mfd_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output mfd_pkg::cfg_t       cfg
);
	mfd_pkg::cfg_t cfg_q;
	logic [2:0]    idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position_offset   <= '0;
			cfg_q.speed_smoothing   <= 16'd6554;
			cfg_q.current_smoothing <= 16'd6554;
			cfg_q.detection_enables <= '0;
			cfg_q.stall_speed       <= 26'd51200;
			cfg_q.stall_current     <= '0;
			cfg_q.crash_sensitivity <= 8'd5;
			cfg_q.motor_on          <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				mfd_pkg::REG_OFFSET:   cfg_q.position_offset   <= pwdata[12:0];
				mfd_pkg::REG_SPD_W:    cfg_q.speed_smoothing   <= pwdata[15:0];
				mfd_pkg::REG_CUR_W:    cfg_q.current_smoothing <= pwdata[15:0];
				mfd_pkg::REG_ENABLES:  cfg_q.detection_enables <= pwdata[1:0];
				mfd_pkg::REG_STALL_SP: cfg_q.stall_speed       <= pwdata[25:0];
				mfd_pkg::REG_STALL_CU: cfg_q.stall_current     <= pwdata[14:0];
				mfd_pkg::REG_CRASH_S:  cfg_q.crash_sensitivity <= pwdata[7:0];
				mfd_pkg::REG_MOTOR_EN: cfg_q.motor_on          <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mfd_pkg::REG_OFFSET:   prdata = {19'd0, cfg_q.position_offset};
			mfd_pkg::REG_SPD_W:    prdata = {16'd0, cfg_q.speed_smoothing};
			mfd_pkg::REG_CUR_W:    prdata = {16'd0, cfg_q.current_smoothing};
			mfd_pkg::REG_ENABLES:  prdata = {30'd0, cfg_q.detection_enables};
			mfd_pkg::REG_STALL_SP: prdata = {6'd0, cfg_q.stall_speed};
			mfd_pkg::REG_STALL_CU: prdata = {17'd0, cfg_q.stall_current};
			mfd_pkg::REG_CRASH_S:  prdata = {24'd0, cfg_q.crash_sensitivity};
			mfd_pkg::REG_MOTOR_EN: prdata = {31'd0, cfg_q.motor_on};
			default:               prdata = '0;
		endcase
	end
endmodule
